@@ rtl/tte_pkg.sv @@
package tte_pkg;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] BOUND_EXACT = 2'd0;

  localparam logic REG_MATE_SCORE  = 1'b0;
  localparam logic REG_MATE_WINDOW = 1'b1;

  localparam logic [15:0] MATE_SCORE_RESET  = 16'd50000;
  localparam logic [7:0]  MATE_WINDOW_RESET = 8'd64;

  localparam logic signed [18:0] SCORE_MIN = -19'sd65536;
  localparam logic signed [18:0] SCORE_MAX = 19'sd65535;

  typedef struct packed {
    logic               valid;
    logic [63:0]        key;
    logic [1:0]         bound;
    logic signed [7:0]  depth;
    logic signed [16:0] score;
    logic [31:0]        move;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic idx_ready;
    logic sweep_last;
    logic is_clear;
  } status_t;

  // Moves a mate-band score between ply-relative and absolute form, with saturation.
  function automatic logic signed [16:0] mate_adjust(input logic signed [16:0] s,
                                                     input logic [7:0] ply,
                                                     input logic signed [17:0] hi,
                                                     input logic to_abs);
    logic signed [18:0] s_w;
    logic signed [18:0] hi_w;
    logic signed [18:0] ply_w;
    logic signed [18:0] sum;
    logic up;
    logic dn;
    s_w   = {{2{s[16]}}, s};
    hi_w  = {hi[17], hi};
    ply_w = {11'b0, ply};
    up    = (s_w >= hi_w);
    dn    = !up && (s_w <= -hi_w);
    if ((up && to_abs) || (dn && !to_abs)) begin
      sum = s_w + ply_w;
    end else if (up || dn) begin
      sum = s_w - ply_w;
    end else begin
      sum = s_w;
    end
    if (sum < SCORE_MIN) begin
      return SCORE_MIN[16:0];
    end else if (sum > SCORE_MAX) begin
      return SCORE_MAX[16:0];
    end
    return sum[16:0];
  endfunction

endpackage

@@ rtl/tte_ctrl.sv @@
module tte_ctrl
  import tte_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   finish;
  logic   accept;

  assign finish      = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE) || (finish && !status_i.is_clear);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = accept;
  assign cmd_o.commit  = finish;
  assign cmd_o.sweep   = (state_q == S_SWEEP);

  assign out_valid_d = finish || (out_valid_q && !out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (status_i.idx_ready) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          if (status_i.is_clear) begin
            state_d = S_SWEEP;
          end else if (accept) begin
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/tte_datapath.sv @@
module tte_datapath
  import tte_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [1:0]         opcode_i,
  input  logic [63:0]        key_i,
  input  logic [31:0]        move_i,
  input  logic signed [7:0]  depth_i,
  input  logic [1:0]         bound_i,
  input  logic signed [16:0] score_i,
  input  logic [7:0]         ply_i,
  input  logic [15:0]        mate_score_i,
  input  logic [7:0]         mate_window_i,
  output logic               hit_o,
  output logic               written_o,
  output logic [31:0]        found_move_o,
  output logic signed [16:0] found_score_o,
  output logic signed [16:0] ply_score_o,
  output logic signed [7:0]  found_depth_o,
  output logic [1:0]         found_bound_o
);

  localparam int unsigned AddrW  = $clog2(TABLE_ENTRIES);
  localparam bit          IsPow2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  logic [1:0]         op_q;
  logic [63:0]        key_q;
  logic [31:0]        move_q;
  logic signed [7:0]  depth_q;
  logic [1:0]         bound_q;
  logic signed [16:0] score_q;
  logic [7:0]         ply_q;

  logic [AddrW-1:0]   idx;
  logic               idx_ready;

  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd_q;
  entry_t             new_entry;
  entry_t             wdata;
  logic [AddrW-1:0]   waddr;
  logic               we;

  logic [AddrW-1:0]   sweep_q, sweep_d;
  logic               sweep_last;

  logic signed [17:0] band_hi;
  logic               hit;
  logic               keep;
  logic               do_write;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      key_q   <= key_i;
      move_q  <= move_i;
      depth_q <= depth_i;
      bound_q <= bound_i;
      score_q <= score_i;
      ply_q   <= ply_i;
    end
  end

  if (IsPow2) begin : g_idx_mask
    assign idx       = key_q[AddrW-1:0];
    assign idx_ready = 1'b1;
  end else begin : g_idx_rem
    // The remainder is formed eight key bits per cycle, most significant first.
    localparam int unsigned BitsPerStep = 8;
    localparam logic [3:0]  NumSteps    = 4'(64 / BitsPerStep);
    localparam logic [AddrW:0] Modulus  = (AddrW + 1)'(TABLE_ENTRIES);

    logic [AddrW-1:0] rem_q, rem_d;
    logic [63:0]      shift_q;
    logic [3:0]       step_q;
    logic [AddrW:0]   r;

    always_comb begin
      r = {1'b0, rem_q};
      for (int b = 0; b < BitsPerStep; b++) begin
        r = {r[AddrW-1:0], shift_q[63-b]};
        if (r >= Modulus) begin
          r = r - Modulus;
        end
      end
      rem_d = r[AddrW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= NumSteps;
      end else if (cmd_i.capture) begin
        step_q <= '0;
      end else if (step_q != NumSteps) begin
        step_q <= step_q + 4'd1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.capture) begin
        rem_q   <= '0;
        shift_q <= key_i;
      end else if (step_q != NumSteps) begin
        rem_q   <= rem_d;
        shift_q <= shift_q << BitsPerStep;
      end
    end

    assign idx       = rem_q;
    assign idx_ready = (step_q == NumSteps);
  end

  assign sweep_last = (sweep_q == AddrW'(TABLE_ENTRIES - 1));
  assign sweep_d    = sweep_last ? '0 : sweep_q + AddrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_d;
    end
  end

  assign band_hi = $signed({2'b00, mate_score_i}) - $signed({10'b0, mate_window_i});

  assign hit      = rd_q.valid && (rd_q.key == key_q);
  assign keep     = hit && (rd_q.depth > depth_q) && (bound_q != BOUND_EXACT);
  assign do_write = cmd_i.commit && (op_q == OP_STORE) && !keep;

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.key   = key_q;
    new_entry.bound = bound_q;
    new_entry.depth = depth_q;
    new_entry.score = mate_adjust(score_q, ply_q, band_hi, 1'b1);
    new_entry.move  = move_q;
  end

  assign we    = cmd_i.sweep || do_write;
  assign waddr = cmd_i.sweep ? sweep_q : idx;
  assign wdata = cmd_i.sweep ? entry_t'('0) : new_entry;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o         <= 1'b0;
      written_o     <= 1'b0;
      found_move_o  <= '0;
      found_score_o <= '0;
      ply_score_o   <= '0;
      found_depth_o <= '0;
      found_bound_o <= '0;
      case (op_q)
        OP_PROBE: begin
          if (hit) begin
            hit_o         <= 1'b1;
            found_move_o  <= rd_q.move;
            found_score_o <= rd_q.score;
            ply_score_o   <= mate_adjust(rd_q.score, ply_q, band_hi, 1'b0);
            found_depth_o <= rd_q.depth;
            found_bound_o <= rd_q.bound;
          end
        end
        OP_STORE: begin
          written_o <= !keep;
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o.idx_ready  = idx_ready;
  assign status_o.sweep_last = sweep_last;
  assign status_o.is_clear   = (op_q == OP_CLEAR);

endmodule

@@ rtl/transposition_table_engine.sv @@
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o    opcode, key, move, depth, bound, score, ply
// out       output     out_valid_o / out_ready_i  hit, written, found_*, ply_score
// cfg       input      psel / penable / pready    paddr, pwrite, pwdata, prdata
//
// With a power-of-two table a probe or store is a memory read in S_READ, then an S_EXEC
// step that compares, writes the slot and loads the output register.
// With other table sizes S_READ also waits while the slot index is reduced from the key.
// Reset and the clear opcode sweep the table one slot per cycle, and no beat is accepted
// meanwhile; the clear result is delivered as the sweep starts.
// A held output beat stalls the block only once the next result is ready to be loaded.
module transposition_table_engine
  import tte_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [63:0]        key_i,
  input  logic [31:0]        move_i,
  input  logic signed [7:0]  depth_i,
  input  logic [1:0]         bound_i,
  input  logic signed [16:0] score_i,
  input  logic [7:0]         ply_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic               written_o,
  output logic [31:0]        found_move_o,
  output logic signed [16:0] found_score_o,
  output logic signed [16:0] ply_score_o,
  output logic signed [7:0]  found_depth_o,
  output logic [1:0]         found_bound_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t        cmd;
  status_t     status;
  logic [15:0] mate_score_q;
  logic [7:0]  mate_window_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_score_q  <= MATE_SCORE_RESET;
      mate_window_q <= MATE_WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_MATE_SCORE:  mate_score_q  <= pwdata[15:0];
        REG_MATE_WINDOW: mate_window_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MATE_SCORE:  prdata = {16'b0, mate_score_q};
      REG_MATE_WINDOW: prdata = {24'b0, mate_window_q};
      default:         prdata = '0;
    endcase
  end

  tte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tte_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .move_i        (move_i),
    .depth_i       (depth_i),
    .bound_i       (bound_i),
    .score_i       (score_i),
    .ply_i         (ply_i),
    .mate_score_i  (mate_score_q),
    .mate_window_i (mate_window_q),
    .hit_o         (hit_o),
    .written_o     (written_o),
    .found_move_o  (found_move_o),
    .found_score_o (found_score_o),
    .ply_score_o   (ply_score_o),
    .found_depth_o (found_depth_o),
    .found_bound_o (found_bound_o)
  );

`ifndef ASSERT_OFF
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep |-> !in_ready_o)
    else $error("Input beat offered while the table is being swept.");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("Result loaded over an output beat that was not taken.");

  a_sweep_excludes_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.sweep && (cmd.commit || cmd.capture)))
    else $error("Sweep overlaps item processing.");

  a_commit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> $past(status.idx_ready))
    else $error("Result committed before the slot index was ready.");
`endif

endmodule

@@ test/tb_transposition_table_engine.sv @@
module tb_transposition_table_engine;
  import tte_pkg::*;

  localparam int unsigned TT_ENTRIES = 65536;
  localparam int KEY_POOL = 24;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;
  localparam logic [1:0] BOUND_ODD = 2'd3;

  localparam logic [63:0] KEY_ZERO = 64'h0;
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_ALIAS = 64'h8000_0000_0000_FFFF;
  localparam logic [63:0] KEY_DEEP = 64'h0F0F_1234_5678_0042;
  localparam logic [63:0] KEY_MATE_HI = 64'hA5A5_0000_0000_1001;
  localparam logic [63:0] KEY_MATE_LO = 64'hA5A5_0000_0000_1002;
  localparam logic [63:0] KEY_OVERLAP_HI = 64'hA5A5_0000_0000_1003;
  localparam logic [63:0] KEY_OVERLAP_LO = 64'hA5A5_0000_0000_1004;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [63:0]        key;
    logic [31:0]        move;
    logic signed [7:0]  depth;
    logic [1:0]         bound;
    logic signed [16:0] score;
    logic [7:0]         ply;
  } tt_request_t;

  typedef struct packed {
    logic               hit;
    logic               written;
    logic [31:0]        move;
    logic signed [16:0] score;
    logic signed [16:0] ply_score;
    logic signed [7:0]  depth;
    logic [1:0]         bound;
  } tt_result_t;

  typedef enum {BAND_NONE, BAND_UPPER, BAND_LOWER} band_e;
  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_RARE} rx_pattern_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         opcode_i = '0;
  logic [63:0]        key_i = '0;
  logic [31:0]        move_i = '0;
  logic signed [7:0]  depth_i = '0;
  logic [1:0]         bound_i = '0;
  logic signed [16:0] score_i = '0;
  logic [7:0]         ply_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               hit_o;
  logic               written_o;
  logic [31:0]        found_move_o;
  logic signed [16:0] found_score_o;
  logic signed [16:0] ply_score_o;
  logic signed [7:0]  found_depth_o;
  logic [1:0]         found_bound_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  entry_t      tt_mirror [TT_ENTRIES];
  logic [63:0] key_pool [KEY_POOL];
  logic [15:0] cfg_mate_score;
  logic [7:0]  cfg_mate_window;
  tt_result_t  expected_results [$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          offering = 1'b0;
  bit          hold_off_request = 1'b0;

  transposition_table_engine #(.TABLE_ENTRIES(TT_ENTRIES)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .opcode_i(opcode_i), .key_i(key_i), .move_i(move_i), .depth_i(depth_i),
    .bound_i(bound_i), .score_i(score_i), .ply_i(ply_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .hit_o(hit_o), .written_o(written_o), .found_move_o(found_move_o),
    .found_score_o(found_score_o), .ply_score_o(ply_score_o),
    .found_depth_o(found_depth_o), .found_bound_o(found_bound_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [16:0] clamp_score(int v);
    int c;
    c = v;
    if (c < SCORE_MIN) begin
      c = SCORE_MIN;
    end else if (c > SCORE_MAX) begin
      c = SCORE_MAX;
    end
    return c[16:0];
  endfunction

  function automatic band_e band_of(int s);
    int hi;
    hi = int'(cfg_mate_score) - int'(cfg_mate_window);
    if (s >= hi) return BAND_UPPER;
    if (s <= -hi) return BAND_LOWER;
    return BAND_NONE;
  endfunction

  function automatic void wipe_mirror();
    foreach (tt_mirror[i]) tt_mirror[i] = '0;
  endfunction

  function automatic tt_result_t predict_outcome(tt_request_t req);
    tt_result_t  res;
    entry_t      slot;
    int unsigned idx;
    int          s;
    int          p;
    band_e       side;
    res = '0;
    idx = 32'(req.key % TT_ENTRIES);
    slot = tt_mirror[idx];
    p = req.ply;
    case (req.opcode)
      OP_PROBE: begin
        if (slot.valid && slot.key == req.key) begin
          s = $signed(slot.score);
          side = band_of(s);
          if (side == BAND_UPPER) begin
            s = s - p;
          end else if (side == BAND_LOWER) begin
            s = s + p;
          end
          res.hit = 1'b1;
          res.move = slot.move;
          res.score = slot.score;
          res.ply_score = clamp_score(s);
          res.depth = slot.depth;
          res.bound = slot.bound;
        end
      end
      OP_STORE: begin
        s = $signed(req.score);
        side = band_of(s);
        if (side == BAND_UPPER) begin
          s = s + p;
        end else if (side == BAND_LOWER) begin
          s = s - p;
        end
        if (!(slot.valid && slot.key == req.key && $signed(slot.depth) > $signed(req.depth)
              && req.bound != BOUND_EXACT)) begin
          slot.valid = 1'b1;
          slot.key = req.key;
          slot.move = req.move;
          slot.score = clamp_score(s);
          slot.depth = req.depth;
          slot.bound = req.bound;
          tt_mirror[idx] = slot;
          res.written = 1'b1;
        end
      end
      OP_CLEAR: wipe_mirror();
      default: ;
    endcase
    return res;
  endfunction

  function automatic tt_request_t mk_request(logic [1:0] op, logic [63:0] key,
                                             logic [31:0] move, logic signed [7:0] depth,
                                             logic [1:0] bound, logic signed [16:0] score,
                                             logic [7:0] ply);
    tt_request_t req;
    req.opcode = op;
    req.key = key;
    req.move = move;
    req.depth = depth;
    req.bound = bound;
    req.score = score;
    req.ply = ply;
    return req;
  endfunction

  function automatic logic signed [16:0] rand_score();
    int          hi;
    int          v;
    logic [31:0] r;
    hi = int'(cfg_mate_score) - int'(cfg_mate_window);
    r = $urandom;
    case ($urandom_range(0, 4))
      0: v = hi - 3 + int'($urandom_range(0, cfg_mate_window + 6));
      1: v = -hi + 3 - int'($urandom_range(0, cfg_mate_window + 6));
      2: v = r[0] ? int'(SCORE_MAX) : int'(SCORE_MIN);
      default: v = $signed(r[16:0]);
    endcase
    return clamp_score(v);
  endfunction

  function automatic tt_request_t random_request();
    tt_request_t req;
    logic [31:0] r;
    int          t;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 46) begin
      req.opcode = OP_PROBE;
    end else if (pick < 94) begin
      req.opcode = OP_STORE;
    end else begin
      req.opcode = OP_NOP;
    end
    if ($urandom_range(0, 9) < 8) begin
      req.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      req.key = {$urandom, $urandom};
    end
    req.move = $urandom;
    r = $urandom;
    if (r[31]) begin
      req.depth = r[7:0];
    end else begin
      t = int'($urandom_range(0, 6)) - 3;
      req.depth = t[7:0];
    end
    req.bound = 2'($urandom_range(0, 3));
    req.score = rand_score();
    req.ply = 8'($urandom_range(0, 255));
    return req;
  endfunction

  task automatic send_beat(tt_request_t req);
    int gap;
    if (burst_left == 0) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i <= req.opcode;
    key_i <= req.key;
    move_i <= req.move;
    depth_i <= req.depth;
    bound_i <= req.bound;
    score_i <= req.score;
    ply_i <= req.ply;
    offering = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_results.push_back(predict_outcome(req));
  endtask

  task automatic wait_idle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic program_reg(logic idx, logic [31:0] value, logic [31:0] mask);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if ((prdata & mask) !== (value & mask)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value & mask, prdata & mask);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mate(logic [15:0] mate, logic [7:0] window);
    wait_idle();
    program_reg(REG_MATE_SCORE, {16'd0, mate}, 32'h0000_FFFF);
    program_reg(REG_MATE_WINDOW, {24'd0, window}, 32'h0000_00FF);
    cfg_mate_score = mate;
    cfg_mate_window = window;
  endtask

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    tt_result_t want;
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no request pending");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("hit", want.hit, hit_o);
        check_field("written", want.written, written_o);
        check_field("found_move", want.move, found_move_o);
        check_field("found_score", want.score, found_score_o);
        check_field("ply_score", want.ply_score, ply_score_o);
        check_field("found_depth", want.depth, found_depth_o);
        check_field("found_bound", want.bound, found_bound_o);
      end
    end
  end

  initial begin : receiver
    rx_pattern_e pattern;
    int          pattern_left;
    pattern = RX_ALWAYS;
    pattern_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (pattern_left == 0) begin
          pattern = rx_pattern_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(16, 200);
        end
        pattern_left--;
        case (pattern)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
          RX_HALF:   out_ready_i <= ($urandom_range(0, 1) != 0);
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic test_reset_state();
    send_beat(mk_request(OP_PROBE, KEY_ZERO, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    send_beat(mk_request(OP_PROBE, KEY_ONES, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd255));
    wait_idle();
  endtask

  task automatic test_store_probe();
    send_beat(mk_request(OP_STORE, KEY_ZERO, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    send_beat(mk_request(OP_PROBE, KEY_ZERO, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    send_beat(mk_request(OP_STORE, KEY_ONES, 32'hFFFF_FFFF, 8'sd127, BOUND_ODD, 17'sd65535,
                         8'd255));
    send_beat(mk_request(OP_PROBE, KEY_ONES, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd255));
    send_beat(mk_request(OP_PROBE, KEY_ALIAS, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    send_beat(mk_request(OP_STORE, KEY_ALIAS, 32'd1, 8'(-128), BOUND_UPPER, 17'(-65536),
                         8'd255));
    send_beat(mk_request(OP_PROBE, KEY_ALIAS, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd1));
    wait_idle();
  endtask

  task automatic test_replacement();
    send_beat(mk_request(OP_STORE, KEY_DEEP, 32'hA, 8'sd10, BOUND_LOWER, 17'sd100, 8'd3));
    send_beat(mk_request(OP_STORE, KEY_DEEP, 32'hB, 8'sd9, BOUND_LOWER, 17'sd200, 8'd3));
    send_beat(mk_request(OP_STORE, KEY_DEEP, 32'hC, 8'sd9, BOUND_ODD, 17'sd300, 8'd3));
    send_beat(mk_request(OP_STORE, KEY_DEEP, 32'hD, 8'sd9, BOUND_EXACT, 17'(-400), 8'd3));
    send_beat(mk_request(OP_PROBE, KEY_DEEP, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    wait_idle();
  endtask

  task automatic test_unused_opcode();
    send_beat(mk_request(OP_NOP, KEY_ONES, 32'hFFFF_FFFF, 8'(-1), BOUND_ODD, 17'(-1), 8'd255));
    wait_idle();
  endtask

  task automatic test_mate_bands();
    set_mate(16'hFFFF, 8'hFF);
    send_beat(mk_request(OP_STORE, KEY_MATE_HI, 32'h11, 8'sd5, BOUND_EXACT, 17'sd65500, 8'd200));
    send_beat(mk_request(OP_PROBE, KEY_MATE_HI, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd255));
    send_beat(mk_request(OP_STORE, KEY_MATE_LO, 32'h22, 8'sd5, BOUND_LOWER, 17'(-65536),
                         8'd100));
    send_beat(mk_request(OP_PROBE, KEY_MATE_LO, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    set_mate(16'd1, 8'hFF);
    send_beat(mk_request(OP_STORE, KEY_OVERLAP_HI, 32'h33, 8'sd1, BOUND_EXACT, 17'sd0, 8'd10));
    send_beat(mk_request(OP_PROBE, KEY_OVERLAP_HI, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd20));
    send_beat(mk_request(OP_STORE, KEY_OVERLAP_LO, 32'h44, 8'sd1, BOUND_UPPER, 17'(-300),
                         8'd7));
    send_beat(mk_request(OP_PROBE, KEY_OVERLAP_LO, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd7));
    wait_idle();
  endtask

  task automatic test_clear();
    send_beat(mk_request(OP_CLEAR, KEY_ONES, 32'hFFFF_FFFF, 8'(-1), BOUND_ODD, 17'(-1),
                         8'd255));
    send_beat(mk_request(OP_PROBE, KEY_ALIAS, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    send_beat(mk_request(OP_PROBE, KEY_DEEP, 32'd0, 8'sd0, BOUND_EXACT, 17'sd0, 8'd0));
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_off_request = 1'b1;
    repeat (40) send_beat(random_request());
    wait_idle();
  endtask

  task automatic test_random();
    tt_request_t req;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_mate(16'd50000, 8'd64);
        1: set_mate(16'hFFFF, 8'hFF);
        2: set_mate(16'd1, 8'hFF);
        3: set_mate(16'd1, 8'd0);
        4: set_mate(16'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)));
        default: set_mate(16'hFFFF, 8'd0);
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req = random_request();
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) req.opcode = OP_CLEAR;
        send_beat(req);
      end
    end
    wait_idle();
  endtask

  initial begin
    cfg_mate_score = MATE_SCORE_RESET;
    cfg_mate_window = MATE_WINDOW_RESET;
    wipe_mirror();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = KEY_ZERO;
    key_pool[1] = KEY_ONES;
    for (int i = 3; i < KEY_POOL; i += 2) key_pool[i][15:0] = key_pool[i - 1][15:0];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();
    test_reset_state();
    test_store_probe();
    test_replacement();
    test_unused_opcode();
    test_mate_bands();
    test_clear();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
